@@ design/nhb_pkg.sv @@
// shared types and constants for the navigation history buffer
package nhb_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 8;
    localparam int LIMIT_W  = 8;
    localparam int CMD_W    = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_BACK    = 3'd1,
        CMD_FORWARD = 3'd2,
        CMD_FIRST   = 3'd3,
        CMD_LAST    = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_LOAD = 2'd2
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] page_handle;
    } in_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] entry_out;
        logic                entry_valid;
        logic                can_go_back;
        logic                can_go_forward;
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_count;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic exec;
        logic rd;
        logic load;
    } dp_ctrl_t;

endpackage

@@ design/nhb_ram.sv @@
// generic single write port ram with registered read
module nhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nhb_ctrl.sv @@
// controller state machine for the navigation history buffer
module nhb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output nhb_pkg::dp_ctrl_t ctrl
);

    nhb_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nhb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        case (state_reg)
            nhb_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.exec = in_valid;
                if (in_valid)
                begin
                    state_next = nhb_pkg::ST_READ;
                end
            end
            nhb_pkg::ST_READ:
            begin
                ctrl.rd    = 1'b1;
                state_next = nhb_pkg::ST_LOAD;
            end
            nhb_pkg::ST_LOAD:
            begin
                // wait until the output register is free or being drained
                ctrl.load = !out_valid_reg || out_ready;
                if (ctrl.load)
                begin
                    state_next = nhb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nhb_pkg::ST_IDLE;
            end
        endcase

        if (ctrl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/nhb_dp.sv @@
// datapath: ring pointers, cursor, limit register, entry store and result register
module nhb_dp #(
    parameter int DEPTH = nhb_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nhb_pkg::dp_ctrl_t            ctrl,
    input  nhb_pkg::in_item_t            in_data,
    input  logic                         cfg_valid,
    input  logic [nhb_pkg::LIMIT_W-1:0]  cfg_data,
    output nhb_pkg::out_item_t           out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > nhb_pkg::LIMIT_W) ? CW : nhb_pkg::LIMIT_W;

    logic [AW-1:0]               oldest_reg, oldest_next;
    logic [CW-1:0]               held_reg, held_next;
    logic [AW-1:0]               cursor_reg, cursor_next;
    logic                        report_reg, report_next;
    logic [nhb_pkg::LIMIT_W-1:0] limit_reg;
    nhb_pkg::out_item_t          out_reg;

    logic [LW-1:0]                lim_ext;
    logic [CW-1:0]                lim_eff;
    logic                         held_nz;
    logic                         back_ok;
    logic                         fwd_ok;
    logic [CW-1:0]                kept;
    logic [CW:0]                  add_held;
    logic [CW:0]                  drop;
    logic [CW:0]                  wsum;
    logic [CW:0]                  osum;
    logic [CW:0]                  rsum;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    logic                         we;
    logic [nhb_pkg::HANDLE_W-1:0] rdata;

    // limit clamped to 1 .. DEPTH
    always_comb
    begin
        lim_ext = LW'(limit_reg);
        if (lim_ext == '0)
        begin
            lim_ext = LW'(1);
        end
        else if (lim_ext > LW'(DEPTH))
        begin
            lim_ext = LW'(DEPTH);
        end
        lim_eff = CW'(lim_ext);
    end

    assign held_nz = (held_reg != '0);
    assign back_ok = held_nz && (cursor_reg != '0);
    assign fwd_ok  = held_nz && ((CW'(cursor_reg) + CW'(1)) < held_reg);

    // slot just past the cursor; everything after the cursor is dropped
    assign kept     = held_nz ? (CW'(cursor_reg) + CW'(1)) : '0;
    assign add_held = {1'b0, kept} + (CW + 1)'(1);
    assign drop     = add_held - {1'b0, lim_eff};
    assign wsum     = (CW + 1)'(oldest_reg) + {1'b0, kept};
    assign waddr    = (wsum >= (CW + 1)'(DEPTH)) ? AW'(wsum - (CW + 1)'(DEPTH)) : AW'(wsum);
    assign osum     = (CW + 1)'(oldest_reg) + drop;
    assign rsum     = (CW + 1)'(oldest_reg) + (CW + 1)'(cursor_reg);
    assign raddr    = (rsum >= (CW + 1)'(DEPTH)) ? AW'(rsum - (CW + 1)'(DEPTH)) : AW'(rsum);
    assign we       = ctrl.exec && (in_data.command == nhb_pkg::CMD_ADD);

    always_comb
    begin
        oldest_next = oldest_reg;
        held_next   = held_reg;
        cursor_next = cursor_reg;
        report_next = held_nz;
        case (in_data.command)
            nhb_pkg::CMD_ADD:
            begin
                report_next = 1'b1;
                if (add_held > {1'b0, lim_eff})
                begin
                    oldest_next = (osum >= (CW + 1)'(DEPTH)) ?
                                  AW'(osum - (CW + 1)'(DEPTH)) : AW'(osum);
                    held_next   = lim_eff;
                    cursor_next = AW'(lim_eff - CW'(1));
                end
                else
                begin
                    held_next   = CW'(add_held);
                    cursor_next = AW'(kept);
                end
            end
            nhb_pkg::CMD_BACK:
            begin
                report_next = back_ok;
                if (back_ok)
                begin
                    cursor_next = cursor_reg - AW'(1);
                end
            end
            nhb_pkg::CMD_FORWARD:
            begin
                report_next = fwd_ok;
                if (fwd_ok)
                begin
                    cursor_next = cursor_reg + AW'(1);
                end
            end
            nhb_pkg::CMD_FIRST:
            begin
                if (held_nz)
                begin
                    cursor_next = '0;
                end
            end
            nhb_pkg::CMD_LAST:
            begin
                if (held_nz)
                begin
                    cursor_next = AW'(held_reg - CW'(1));
                end
            end
            default:
            begin
                report_next = held_nz;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg   <= '0;
            cursor_reg <= '0;
            report_reg <= 1'b0;
            limit_reg  <= nhb_pkg::LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (ctrl.exec)
            begin
                oldest_reg <= oldest_next;
                held_reg   <= held_next;
                cursor_reg <= cursor_next;
                report_reg <= report_next;
            end
        end
    end

    nhb_ram #(
        .WIDTH (nhb_pkg::HANDLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_data.page_handle),
        .re    (ctrl.rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            out_reg.entry_out      <= report_reg ? rdata : '0;
            out_reg.entry_valid    <= report_reg;
            out_reg.can_go_back    <= back_ok;
            out_reg.can_go_forward <= fwd_ok;
            out_reg.is_empty       <= !held_nz;
            out_reg.entry_count    <= nhb_pkg::COUNT_W'(held_reg);
        end
    end

    assign out_data = out_reg;

endmodule

@@ design/navigation_history_buffer.sv @@
// a taken input passes the store read, then the result load, before out_valid
// a new command waits for the controller's read and load states of the previous one;
// a new command is taken while the previous result still waits in the output register
// reset: empty history, cursor and oldest slot at zero, entry limit 100
// the entry store has no reset; only data from slots that were written reaches entry_out
module navigation_history_buffer #(
    parameter int DEPTH = nhb_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  nhb_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output nhb_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [nhb_pkg::LIMIT_W-1:0] cfg_data
);

    nhb_pkg::dp_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    nhb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    nhb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
